FILE: src/mcfcd_pkg.sv
// ----------------------------------------------------------------------------
// mcfcd_pkg
// Shared widths, register map, scale constants and control types of the
// mean color frame change detector.
// ----------------------------------------------------------------------------
package mcfcd_pkg;

	localparam int PIX_W        = 8;
	localparam int PIXCNT_W     = 25;
	localparam int THRESH_W     = 17;
	localparam int DIFF_W       = 34;
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_ADDR_W   = 3;
	localparam int NUM_CHAN     = 3;
	localparam int Q16_SHIFT    = 16;
	localparam int CHAN_MAX     = 255;
	localparam int DROP_SCALE   = NUM_CHAN * CHAN_MAX;
	localparam int SCALE_W      = 10;
	localparam int RHS_W        = THRESH_W + PIXCNT_W + SCALE_W;

	localparam logic [PIXCNT_W-1:0] PIXCNT_RESET = PIXCNT_W'(2073600);
	localparam logic [THRESH_W-1:0] THRESH_RESET = '0;

	typedef enum logic {
		REG_PIXEL_COUNT = 1'b0,
		REG_THRESHOLD   = 1'b1
	} mcfcd_reg_t;

	// Control that travels with a frame-end request down the compare pipe
	typedef struct packed {
		logic valid;
		logic have_ref;
	} mcfcd_ctl_t;

endpackage

FILE: src/mcfcd_cfg.sv
// ----------------------------------------------------------------------------
// mcfcd_cfg
// APB register file and the registered drop threshold product
// threshold_q16 * 765 * pixel_count.
// ----------------------------------------------------------------------------
module mcfcd_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mcfcd_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [mcfcd_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [mcfcd_pkg::CFG_DATA_W-1:0]  prdata,
	output logic [mcfcd_pkg::RHS_W-1:0]       rhs
);
	import mcfcd_pkg::*;

	logic [PIXCNT_W-1:0]          pixcnt_q;
	logic [THRESH_W-1:0]          thresh_q;
	logic [THRESH_W+PIXCNT_W-1:0] prod_q;
	logic [RHS_W-1:0]             rhs_q;
	mcfcd_reg_t                   idx;
	logic                         wr;

	assign idx = mcfcd_reg_t'(paddr[2]);
	assign wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixcnt_q <= PIXCNT_RESET;
			thresh_q <= THRESH_RESET;
		end else if (wr) begin
			case (idx)
				REG_PIXEL_COUNT: pixcnt_q <= pwdata[PIXCNT_W-1:0];
				REG_THRESHOLD:   thresh_q <= pwdata[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// Two registered steps: variable product, then constant scale
	always_ff @(posedge clk) begin
		prod_q <= {{PIXCNT_W{1'b0}}, thresh_q} * {{THRESH_W{1'b0}}, pixcnt_q};
		rhs_q  <= {{SCALE_W{1'b0}}, prod_q} * RHS_W'(DROP_SCALE);
	end

	assign rhs = rhs_q;

	always_comb begin
		case (idx)
			REG_PIXEL_COUNT: prdata = CFG_DATA_W'(pixcnt_q);
			REG_THRESHOLD:   prdata = CFG_DATA_W'(thresh_q);
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: src/mcfcd_accum.sv
// ----------------------------------------------------------------------------
// mcfcd_accum
// Input register, per-channel frame sums and the reference sums of the
// previous frame; hands frame totals to the compare pipe.
// ----------------------------------------------------------------------------
module mcfcd_accum #(
	parameter int ACC_W = 32
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       advance,
	input  logic                                       pix_valid,
	input  logic [mcfcd_pkg::PIX_W-1:0]                red,
	input  logic [mcfcd_pkg::PIX_W-1:0]                green,
	input  logic [mcfcd_pkg::PIX_W-1:0]                blue,
	input  logic                                       frame_end,
	output mcfcd_pkg::mcfcd_ctl_t                      ctl_s2,
	output logic [mcfcd_pkg::NUM_CHAN-1:0][ACC_W-1:0]  sum_s2,
	output logic [mcfcd_pkg::NUM_CHAN-1:0][ACC_W-1:0]  ref_s2
);
	import mcfcd_pkg::*;

	logic                                valid_s1;
	logic                                last_s1;
	logic [NUM_CHAN-1:0][PIX_W-1:0]      pix_s1;
	logic [NUM_CHAN-1:0][ACC_W-1:0]      acc_q;
	logic [NUM_CHAN-1:0][ACC_W-1:0]      ref_q;
	logic [NUM_CHAN-1:0][ACC_W-1:0]      total;
	logic                                have_ref_q;
	logic                                close_frame;

	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			total[c] = acc_q[c] + ACC_W'(pix_s1[c]);
		end
	end

	assign close_frame = advance & valid_s1 & last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_s1  <= {blue, green, red};
			last_s1 <= frame_end;
		end
	end

	// Add the pixel, or close the frame and move its totals to the reference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			ref_q      <= '0;
			have_ref_q <= 1'b0;
			ctl_s2     <= '0;
		end else if (advance) begin
			ctl_s2.valid    <= valid_s1 & last_s1;
			ctl_s2.have_ref <= have_ref_q;
			if (valid_s1) begin
				if (last_s1) begin
					acc_q      <= '0;
					ref_q      <= total;
					have_ref_q <= 1'b1;
				end else begin
					acc_q <= total;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (close_frame) begin
			sum_s2 <= total;
			ref_s2 <= ref_q;
		end
	end

endmodule

FILE: src/mcfcd_score.sv
// ----------------------------------------------------------------------------
// mcfcd_score
// Absolute channel differences, score sum, threshold compare and the
// result register.
// ----------------------------------------------------------------------------
module mcfcd_score #(
	parameter int ACC_W = 32
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       advance,
	input  mcfcd_pkg::mcfcd_ctl_t                      ctl_s2,
	input  logic [mcfcd_pkg::NUM_CHAN-1:0][ACC_W-1:0]  sum_s2,
	input  logic [mcfcd_pkg::NUM_CHAN-1:0][ACC_W-1:0]  ref_s2,
	input  logic [mcfcd_pkg::RHS_W-1:0]                rhs,
	output logic                                       res_valid,
	output logic                                       drop_frame,
	output logic                                       was_compared,
	output logic [mcfcd_pkg::DIFF_W-1:0]               difference_total
);
	import mcfcd_pkg::*;

	localparam int SCORE_W = ACC_W + 2;
	localparam int LHS_W   = SCORE_W + Q16_SHIFT;
	localparam int CMP_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;
	localparam int EXT_W   = (SCORE_W > DIFF_W) ? SCORE_W : DIFF_W;

	mcfcd_ctl_t                     ctl_s3, ctl_s4;
	logic [NUM_CHAN-1:0][ACC_W-1:0] diff_s3;
	logic [SCORE_W-1:0]             score_s4;
	logic [CMP_W-1:0]               lhs_ext, rhs_ext;
	logic [EXT_W-1:0]               score_ext;
	logic                           res_valid_q, drop_q, was_q;
	logic [DIFF_W-1:0]              diff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3      <= '0;
			ctl_s4      <= '0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			ctl_s3      <= ctl_s2;
			ctl_s4      <= ctl_s3;
			res_valid_q <= ctl_s4.valid;
		end
	end

	assign lhs_ext   = CMP_W'({score_s4, {Q16_SHIFT{1'b0}}});
	assign rhs_ext   = CMP_W'(rhs);
	assign score_ext = EXT_W'(score_s4);

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				diff_s3[c] <= (sum_s2[c] >= ref_s2[c]) ? (sum_s2[c] - ref_s2[c])
				                                       : (ref_s2[c] - sum_s2[c]);
			end
			// First frame reports a zero score
			score_s4 <= ctl_s3.have_ref ? (SCORE_W'(diff_s3[0]) + SCORE_W'(diff_s3[1])
			                               + SCORE_W'(diff_s3[2])) : '0;
			drop_q   <= ctl_s4.have_ref & (lhs_ext > rhs_ext);
			was_q    <= ctl_s4.have_ref;
			diff_q   <= score_ext[DIFF_W-1:0];
		end
	end

	assign res_valid        = res_valid_q;
	assign drop_frame       = drop_q;
	assign was_compared     = was_q;
	assign difference_total = diff_q;

endmodule

FILE: src/mean_color_frame_change_detector.sv
// ----------------------------------------------------------------------------
// mean_color_frame_change_detector
// Scene change detector on per-frame mean color: sums RGB per frame and
// flags frames whose sums differ too much from the previous frame.
// ----------------------------------------------------------------------------
// Pixels enter one per clock on the pix channel and are summed per channel.
// The pixel with frame_end set closes the frame: its score is the sum of the
// absolute differences of this frame's three channel sums and the previous
// frame's; one result request is offered on res once the closing pixel
// reaches the result register. The frame is flagged in drop_frame when
// score * 65536 > threshold_q16 * 765 * pixel_count; the first frame after
// reset is never compared and reports a zero score. Every frame becomes the
// reference for the next. Sustained rate is one pixel per clock; the
// five-stage pipe (input register, accumulate, difference, score sum,
// compare/result register) advances as a whole and stalls only while a
// result waits on res_ready. Registers: pixel_count at byte address 0
// (reset 2073600) and threshold_q16 at byte address 4 (reset 0); the
// threshold product is rebuilt in its product and scale registers after a write.
module mean_color_frame_change_detector #(
	parameter int COUNT_BITS   = 24,
	parameter int CHANNEL_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mcfcd_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [mcfcd_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [mcfcd_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                              pready,
	// pixel requests
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  logic [mcfcd_pkg::PIX_W-1:0]       red,
	input  logic [mcfcd_pkg::PIX_W-1:0]       green,
	input  logic [mcfcd_pkg::PIX_W-1:0]       blue,
	input  logic                              frame_end,
	// result requests
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic                              drop_frame,
	output logic                              was_compared,
	output logic [mcfcd_pkg::DIFF_W-1:0]      difference_total
);
	import mcfcd_pkg::*;

	// Sums wrap at this width
	localparam int ACC_W = COUNT_BITS + CHANNEL_BITS;

	logic                           advance;
	logic [RHS_W-1:0]               rhs;
	mcfcd_ctl_t                     ctl_s2;
	logic [NUM_CHAN-1:0][ACC_W-1:0] sum_s2;
	logic [NUM_CHAN-1:0][ACC_W-1:0] ref_s2;

	// Advance the whole pipe unless a finished result is held back
	assign advance   = ~res_valid | res_ready;
	assign pix_ready = advance;
	assign pready    = 1'b1;

	mcfcd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.rhs     (rhs)
	);

	mcfcd_accum #(
		.ACC_W (ACC_W)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.pix_valid (pix_valid),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.frame_end (frame_end),
		.ctl_s2    (ctl_s2),
		.sum_s2    (sum_s2),
		.ref_s2    (ref_s2)
	);

	mcfcd_score #(
		.ACC_W (ACC_W)
	) u_score (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (advance),
		.ctl_s2           (ctl_s2),
		.sum_s2           (sum_s2),
		.ref_s2           (ref_s2),
		.rhs              (rhs),
		.res_valid        (res_valid),
		.drop_frame       (drop_frame),
		.was_compared     (was_compared),
		.difference_total (difference_total)
	);

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mean color frame change detector: a table of
// directed pixel frames and register writes, then randomized scenes under
// three backpressure profiles, all scored against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb;
	import mcfcd_pkg::*;

	localparam int COUNT_BITS    = 24;
	localparam int CHANNEL_BITS  = 8;
	localparam int ACC_W         = COUNT_BITS + CHANNEL_BITS;
	localparam int PIPE_SETTLE   = 8;
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_PIXELS = 1800;
	localparam int PHASES        = 3;
	localparam int SEGMENTS      = 5;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             closes;
	} pixel_t;

	typedef struct packed {
		logic              drop;
		logic              compared;
		logic [DIFF_W-1:0] diff;
	} verdict_t;

	typedef enum logic {
		ROW_PIXEL,
		ROW_WRITE
	} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		pixel_t                pix;
		logic                  typed;
		verdict_t              verdict;
		mcfcd_reg_t            reg_sel;
		logic [CFG_DATA_W-1:0] value;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  pix_valid;
	logic                  pix_ready;
	logic [PIX_W-1:0]      red;
	logic [PIX_W-1:0]      green;
	logic [PIX_W-1:0]      blue;
	logic                  frame_end;
	logic                  res_valid;
	logic                  res_ready;
	logic                  drop_frame;
	logic                  was_compared;
	logic [DIFF_W-1:0]     difference_total;

	// Predictor copy of the block state and its registers
	logic [ACC_W-1:0]    sum_red    = '0;
	logic [ACC_W-1:0]    sum_green  = '0;
	logic [ACC_W-1:0]    sum_blue   = '0;
	logic [ACC_W-1:0]    prev_red   = '0;
	logic [ACC_W-1:0]    prev_green = '0;
	logic [ACC_W-1:0]    prev_blue  = '0;
	logic                have_prev  = 1'b0;
	logic [PIXCNT_W-1:0] cfg_pixels = PIXCNT_RESET;
	logic [THRESH_W-1:0] cfg_thresh = THRESH_RESET;

	verdict_t pending_verdicts[$];
	verdict_t want_verdict;
	int       mismatches   = 0;
	int       stall_cycles = 0;
	int       snd_idle_pct = 24;
	int       rcv_idle_pct = 58;

	mean_color_frame_change_detector #(
		.COUNT_BITS  (COUNT_BITS),
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_top (.*);

	// Toggle every half period of 10 ns
	always #5 clk = ~clk;

	function automatic logic [DIFF_W-1:0] sum_gap(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
		return (a >= b) ? DIFF_W'(a - b) : DIFF_W'(b - a);
	endfunction

	// Accumulate one pixel; on the closing pixel score the frame against the
	// previous one and make it the new reference
	task automatic predict_pixel(input pixel_t p, output logic closed, output verdict_t v);
		logic [DIFF_W-1:0] score;
		logic [63:0]       lhs;
		logic [63:0]       rhs;
		sum_red   = sum_red + ACC_W'(p.red);
		sum_green = sum_green + ACC_W'(p.green);
		sum_blue  = sum_blue + ACC_W'(p.blue);
		closed = p.closes;
		v = '0;
		if (p.closes) begin
			if (have_prev) begin
				score = sum_gap(sum_red, prev_red) + sum_gap(sum_green, prev_green)
					+ sum_gap(sum_blue, prev_blue);
				lhs = 64'(score) << Q16_SHIFT;
				rhs = 64'(cfg_thresh) * 64'(DROP_SCALE) * 64'(cfg_pixels);
				v.drop     = lhs > rhs;
				v.compared = 1'b1;
				v.diff     = score;
			end
			prev_red   = sum_red;
			prev_green = sum_green;
			prev_blue  = sum_blue;
			sum_red    = '0;
			sum_green  = '0;
			sum_blue   = '0;
			have_prev  = 1'b1;
		end
	endtask

	// Offer one pixel request after random sender idling; hold it until taken
	task automatic send_pixel(input pixel_t p, input logic use_typed, input verdict_t typed_v);
		logic     closed;
		verdict_t v;
		@(negedge clk);
		while ($urandom_range(99, 0) < snd_idle_pct) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix_valid <= 1'b1;
		red       <= p.red;
		green     <= p.green;
		blue      <= p.blue;
		frame_end <= p.closes;
		do @(posedge clk); while (!pix_ready);
		predict_pixel(p, closed, v);
		if (closed)
			pending_verdicts.push_back(use_typed ? typed_v : v);
	endtask

	// Drop the pixel request, let every expected result drain, then let the
	// pipe settle past its latency
	task automatic wait_idle();
		@(negedge clk);
		pix_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	// Write a register over APB while idle, then read it back
	task automatic write_register(input mcfcd_reg_t sel, input logic [CFG_DATA_W-1:0] value);
		logic [CFG_DATA_W-1:0] stored;
		wait_idle();
		stored = (sel == REG_PIXEL_COUNT) ? CFG_DATA_W'(value[PIXCNT_W-1:0])
			: CFG_DATA_W'(value[THRESH_W-1:0]);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (sel == REG_PIXEL_COUNT)
			cfg_pixels = value[PIXCNT_W-1:0];
		else
			cfg_thresh = value[THRESH_W-1:0];
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== stored) begin
			$display("%0t readback of register %s: expected 0x%0h, got 0x%0h",
				$time, sel.name(), stored, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] jitter(logic [PIX_W-1:0] base, int amp);
		int v;
		if (amp < 0)
			return PIX_W'($urandom);
		v = int'(base) + int'($urandom_range(2 * amp, 0)) - amp;
		if (v < 0)
			v = 0;
		if (v > CHAN_MAX)
			v = CHAN_MAX;
		return PIX_W'(v);
	endfunction

	function automatic stim_row_t pix_row(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
			logic [PIX_W-1:0] b, logic last_pix);
		stim_row_t row;
		row.kind    = ROW_PIXEL;
		row.pix     = '{red: r, green: g, blue: b, closes: last_pix};
		row.typed   = 1'b0;
		row.verdict = '0;
		row.reg_sel = REG_PIXEL_COUNT;
		row.value   = '0;
		return row;
	endfunction

	function automatic stim_row_t pix_known(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
			logic [PIX_W-1:0] b, logic drop, logic compared, logic [DIFF_W-1:0] diff);
		stim_row_t row;
		row = pix_row(r, g, b, 1'b1);
		row.typed   = 1'b1;
		row.verdict = '{drop: drop, compared: compared, diff: diff};
		return row;
	endfunction

	function automatic stim_row_t write_row(mcfcd_reg_t sel, logic [CFG_DATA_W-1:0] value);
		stim_row_t row;
		row = pix_row('0, '0, '0, 1'b0);
		row.kind    = ROW_WRITE;
		row.reg_sel = sel;
		row.value   = value;
		return row;
	endfunction

	// Receiver: drop res_ready at random, one decision per cycle
	always @(negedge clk)
		res_ready <= ($urandom_range(99, 0) >= rcv_idle_pct);

	// Score every accepted result request against the oldest expectation
	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t unexpected result: drop_frame %0d was_compared %0d difference_total %0d",
					$time, drop_frame, was_compared, difference_total);
				mismatches++;
			end else begin
				want_verdict = pending_verdicts.pop_front();
				if (drop_frame !== want_verdict.drop) begin
					$display("%0t drop_frame: expected %0d, got %0d",
						$time, want_verdict.drop, drop_frame);
					mismatches++;
				end
				if (was_compared !== want_verdict.compared) begin
					$display("%0t was_compared: expected %0d, got %0d",
						$time, want_verdict.compared, was_compared);
					mismatches++;
				end
				if (difference_total !== want_verdict.diff) begin
					$display("%0t difference_total: expected %0d, got %0d",
						$time, want_verdict.diff, difference_total);
					mismatches++;
				end
			end
		end
	end

	// Count cycles in which no request or register access moves
	always @(posedge clk) begin
		if ((pix_valid && pix_ready) || (res_valid && res_ready) || (psel && penable && pready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("[mean_color_frame_change_detector] ERROR");
		$finish;
	end

	initial begin
		stim_row_t        rows[$];
		pixel_t           p;
		int               frame_len;
		int               amp;
		int               seg_pixels;
		logic [PIX_W-1:0] base_r;
		logic [PIX_W-1:0] base_g;
		logic [PIX_W-1:0] base_b;

		// Hold every input at a known value through reset
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		pix_valid = 1'b0;
		red       = '0;
		green     = '0;
		blue      = '0;
		frame_end = 1'b0;
		res_ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// First frame after reset is never compared
		rows.push_back(pix_known(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 34'd0));
		// Zero threshold: any change drops, no change keeps
		rows.push_back(pix_known(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 34'd765));
		rows.push_back(pix_known(8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 34'd0));
		rows.push_back(pix_known(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 34'd765));
		// Multi-pixel frames, ordinary pixels give no result
		rows.push_back(pix_row(8'd255, 8'd0, 8'd0, 1'b0));
		rows.push_back(pix_row(8'd0, 8'd255, 8'd0, 1'b0));
		rows.push_back(pix_known(8'd0, 8'd0, 8'd255, 1'b1, 1'b1, 34'd765));
		rows.push_back(pix_row(8'd128, 8'd64, 8'd32, 1'b0));
		rows.push_back(pix_row(8'd1, 8'd2, 8'd3, 1'b0));
		rows.push_back(pix_known(8'd127, 8'd191, 8'd223, 1'b1, 1'b1, 34'd6));
		// Threshold of exactly one over a single-pixel count: equality keeps
		rows.push_back(write_row(REG_PIXEL_COUNT, 32'd1));
		rows.push_back(write_row(REG_THRESHOLD, 32'd65536));
		rows.push_back(pix_known(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 34'd771));
		rows.push_back(pix_known(8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 34'd765));
		// Zero pixel count with the threshold above one
		rows.push_back(write_row(REG_THRESHOLD, 32'd131071));
		rows.push_back(write_row(REG_PIXEL_COUNT, 32'd0));
		rows.push_back(pix_known(8'd254, 8'd255, 8'd255, 1'b1, 1'b1, 34'd1));
		rows.push_back(pix_known(8'd254, 8'd255, 8'd255, 1'b0, 1'b1, 34'd0));
		// Widest pixel count, and a count that differs from the frame length
		rows.push_back(write_row(REG_PIXEL_COUNT, 32'h01FF_FFFF));
		for (int i = 0; i < 5; i++)
			rows.push_back(pix_row(8'd255, 8'd255, 8'd255, i == 4));
		rows.push_back(pix_row(8'd0, 8'd0, 8'd0, 1'b1));
		rows.push_back(write_row(REG_PIXEL_COUNT, 32'd16777216));
		rows.push_back(write_row(REG_THRESHOLD, 32'd65536));
		rows.push_back(pix_row(8'd255, 8'd255, 8'd255, 1'b1));
		rows.push_back(write_row(REG_THRESHOLD, 32'd1));
		rows.push_back(write_row(REG_PIXEL_COUNT, 32'd1));
		rows.push_back(pix_row(8'd1, 8'd0, 8'd0, 1'b1));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_WRITE)
				write_register(rows[i].reg_sel, rows[i].value);
			else
				send_pixel(rows[i].pix, rows[i].typed, rows[i].verdict);
		end

		base_r = '0;
		base_g = '0;
		base_b = '0;
		for (int phase = 0; phase < PHASES; phase++) begin
			// Receiver-heavy idling, then sender-heavy, then none
			snd_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 58 : 0;
			rcv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 24 : 0;
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				// Keep most counts near the frame length so verdicts split
				if ($urandom_range(3, 0) == 0)
					write_register(REG_PIXEL_COUNT, $urandom);
				else
					write_register(REG_PIXEL_COUNT, $urandom_range(16, 1));
				if ($urandom_range(3, 0) == 0)
					write_register(REG_THRESHOLD, $urandom);
				else
					write_register(REG_THRESHOLD, $urandom_range(8192, 0));
				seg_pixels = 0;
				while (seg_pixels < RANDOM_PIXELS / (PHASES * SEGMENTS)) begin
					frame_len = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 13)
						: $urandom_range(12, 1);
					// Mostly a steady scene with small noise, sometimes a cut or pure noise
					case ($urandom_range(7, 0))
						0: begin
							base_r = PIX_W'($urandom);
							base_g = PIX_W'($urandom);
							base_b = PIX_W'($urandom);
							amp = $urandom_range(16, 0);
						end
						1: amp = -1;
						default: amp = $urandom_range(8, 0);
					endcase
					for (int i = 0; i < frame_len; i++) begin
						p.red    = jitter(base_r, amp);
						p.green  = jitter(base_g, amp);
						p.blue   = jitter(base_b, amp);
						p.closes = (i == frame_len - 1);
						send_pixel(p, 1'b0, '0);
					end
					seg_pixels += frame_len;
					// Now and then hold pixels until every result is out
					if ($urandom_range(24, 0) == 0)
						wait_idle();
				end
			end
		end

		wait_idle();
		if (pending_verdicts.size() != 0) begin
			$display("%0t %0d results never arrived", $time, pending_verdicts.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("[mean_color_frame_change_detector] OK");
		else
			$display("[mean_color_frame_change_detector] ERROR");
		$finish;
	end

endmodule
